/* design/yuvmv_pkg.sv */
// Package for the YUV plane mean/variance block: datapath widths, step
// counts and plane codes. Depends on nothing.
package yuvmv_pkg;

    // Plane size limit and mean fraction
    localparam int MAX_LUMA_PIXELS = 4194304;
    localparam int MEAN_FRAC_BITS  = 8;

    // Field widths
    localparam int LUMA_W  = 23;
    localparam int PIX_W   = 8;
    localparam int PLANE_W = 2;
    localparam int FRAME_W = 16;
    localparam int MEAN_W  = 16;
    localparam int VAR_W   = 14;

    // Accumulator widths
    localparam int COUNT_W = 23;
    localparam int SUM_W   = 30;
    localparam int SQ_W    = 38;

    // Serial multiplier and divider widths
    localparam int MCAND_W     = SQ_W + 1;
    localparam int PROD_W      = 61;
    localparam int REM_W       = COUNT_W;
    localparam int Q1_W        = SQ_W + 1;
    localparam int MEAN_DIV_W  = SUM_W + MEAN_FRAC_BITS;
    localparam int MUL_STEPS   = SUM_W;
    localparam int STEP_W      = 6;

    // Plane codes
    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

endpackage

/* design/yuv_plane_mean_variance.sv */
// Top level of the YUV plane mean/variance block: accumulators, bit-serial
// multiplier, shared restoring divider and output register.
// Depends on yuvmv_pkg.

// Pixels of 4:2:0 frames (Y plane of luma_pixels rounded down to a multiple of
// four and clamped to 4..MAX_LUMA_PIXELS samples, then U and V of a quarter of
// that each) are taken one per clock while a plane is running. On the last
// pixel of a plane the input stalls through the S_PREP setup state, an MSB-first
// shift-and-add multiplier forming N*(sumsq + floor(N/2)) and sum^2, then a
// one-bit-per-cycle restoring divider run three times (38 steps for the Q8.8
// mean, 61 and 39 steps for the two divisions by N that give the rounded
// variance), and the S_FIN state that loads the result register. A further stall
// follows only while an earlier result is still held in the output register.
// The luma size register is written through a port that is always ready.
module yuv_plane_mean_variance
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [yuvmv_pkg::LUMA_W-1:0]    luma_pixels,

    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [yuvmv_pkg::PIX_W-1:0]     pixel,

    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [yuvmv_pkg::PLANE_W-1:0]   plane,
    output logic [yuvmv_pkg::FRAME_W-1:0]   frame_number,
    output logic [yuvmv_pkg::MEAN_W-1:0]    mean_q8,
    output logic [yuvmv_pkg::VAR_W-1:0]     variance
);

    // Sequencer states
    localparam logic [2:0] S_ACC   = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DMEAN = 3'd3;
    localparam logic [2:0] S_DVAR1 = 3'd4;
    localparam logic [2:0] S_DVAR2 = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]                         state_reg, state_next;
    logic [yuvmv_pkg::LUMA_W-1:0]       luma_reg;
    logic [yuvmv_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [yuvmv_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [yuvmv_pkg::SQ_W-1:0]         sumsq_reg, sumsq_next;
    logic [yuvmv_pkg::PLANE_W-1:0]      plane_reg, plane_next;
    logic [yuvmv_pkg::FRAME_W-1:0]      frame_reg, frame_next;
    logic [yuvmv_pkg::STEP_W-1:0]       step_reg, step_next;

    logic [yuvmv_pkg::MCAND_W-1:0]      mcand_reg, mcand_next;
    logic [yuvmv_pkg::MUL_STEPS-1:0]    nbits_reg, nbits_next;
    logic [yuvmv_pkg::MUL_STEPS-1:0]    sbits_reg, sbits_next;
    logic [yuvmv_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [yuvmv_pkg::PROD_W-1:0]       sqr_reg, sqr_next;
    logic [yuvmv_pkg::PROD_W-1:0]       dq_reg, dq_next;
    logic [yuvmv_pkg::REM_W-1:0]        rem_reg, rem_next;
    logic [yuvmv_pkg::MEAN_W-1:0]       mean_reg, mean_next;
    logic [yuvmv_pkg::VAR_W-1:0]        var_reg, var_next;

    logic                               out_valid_reg, out_valid_next;
    logic [yuvmv_pkg::PLANE_W-1:0]      out_plane_reg, out_plane_next;
    logic [yuvmv_pkg::FRAME_W-1:0]      out_frame_reg, out_frame_next;
    logic [yuvmv_pkg::MEAN_W-1:0]       out_mean_reg, out_mean_next;
    logic [yuvmv_pkg::VAR_W-1:0]        out_var_reg, out_var_next;

    logic                               accept;
    logic                               plane_end;
    logic                               out_load;
    logic [yuvmv_pkg::COUNT_W-1:0]      count_inc;
    logic [yuvmv_pkg::COUNT_W-1:0]      luma_masked;
    logic [yuvmv_pkg::COUNT_W-1:0]      luma_len;
    logic [yuvmv_pkg::COUNT_W-1:0]      plane_len;
    logic [2*yuvmv_pkg::PIX_W-1:0]      pix_sq;
    logic [yuvmv_pkg::REM_W:0]          div_trial;
    logic [yuvmv_pkg::REM_W:0]          div_diff;
    logic                               div_ge;
    logic [yuvmv_pkg::REM_W-1:0]        rem_step;
    logic [yuvmv_pkg::PROD_W-1:0]       dq_step;

    // Handshake outputs
    assign cfg_ready    = 1'b1;
    assign pixel_stall  = (state_reg != S_ACC);
    assign accept       = pixel_valid && !pixel_stall;
    assign result_valid = out_valid_reg;
    assign plane        = out_plane_reg;
    assign frame_number = out_frame_reg;
    assign mean_q8      = out_mean_reg;
    assign variance     = out_var_reg;

    // Plane length: luma size rounded down to four, clamped, quartered for chroma
    always_comb
    begin
        luma_masked = {luma_reg[yuvmv_pkg::LUMA_W-1:2], 2'b00};
        if (luma_masked < yuvmv_pkg::COUNT_W'(4))
        begin
            luma_len = yuvmv_pkg::COUNT_W'(4);
        end
        else if (luma_masked > yuvmv_pkg::COUNT_W'(yuvmv_pkg::MAX_LUMA_PIXELS))
        begin
            luma_len = yuvmv_pkg::COUNT_W'(yuvmv_pkg::MAX_LUMA_PIXELS);
        end
        else
        begin
            luma_len = luma_masked;
        end
        plane_len = (plane_reg == yuvmv_pkg::PLANE_Y) ? luma_len : (luma_len >> 2);
    end

    assign count_inc = count_reg + yuvmv_pkg::COUNT_W'(1);
    assign plane_end = accept && (count_inc >= plane_len);
    assign pix_sq    = {{yuvmv_pkg::PIX_W{1'b0}}, pixel} * {{yuvmv_pkg::PIX_W{1'b0}}, pixel};

    // One restoring divide step; the divisor is the sample count
    assign div_trial = {rem_reg, dq_reg[yuvmv_pkg::PROD_W-1]};
    assign div_diff  = div_trial - {1'b0, count_reg};
    assign div_ge    = (div_trial >= {1'b0, count_reg});
    assign rem_step  = div_ge ? div_diff[yuvmv_pkg::REM_W-1:0]
                              : div_trial[yuvmv_pkg::REM_W-1:0];
    assign dq_step   = {dq_reg[yuvmv_pkg::PROD_W-2:0], div_ge};

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        sumsq_next     = sumsq_reg;
        plane_next     = plane_reg;
        frame_next     = frame_reg;
        step_next      = step_reg;
        mcand_next     = mcand_reg;
        nbits_next     = nbits_reg;
        sbits_next     = sbits_reg;
        prod_next      = prod_reg;
        sqr_next       = sqr_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        mean_next      = mean_reg;
        var_next       = var_reg;
        out_valid_next = out_valid_reg;
        out_plane_next = out_plane_reg;
        out_frame_next = out_frame_reg;
        out_mean_next  = out_mean_reg;
        out_var_next   = out_var_reg;
        out_load       = 1'b0;

        // Result taken downstream
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_ACC:
            begin
                if (accept)
                begin
                    count_next = count_inc;
                    sum_next   = sum_reg + yuvmv_pkg::SUM_W'(pixel);
                    sumsq_next = sumsq_reg + yuvmv_pkg::SQ_W'(pix_sq);
                    if (plane_end)
                    begin
                        state_next = S_PREP;
                    end
                end
            end

            // Multiplicand sumsq + floor(N/2) folds the rounding half in
            S_PREP:
            begin
                mcand_next = {1'b0, sumsq_reg} + yuvmv_pkg::MCAND_W'(count_reg >> 1);
                nbits_next = yuvmv_pkg::MUL_STEPS'(count_reg);
                sbits_next = sum_reg;
                prod_next  = '0;
                sqr_next   = '0;
                step_next  = yuvmv_pkg::STEP_W'(yuvmv_pkg::MUL_STEPS - 1);
                state_next = S_MUL;
            end

            // MSB-first shift and add: N*mcand and sum*sum side by side
            S_MUL:
            begin
                prod_next  = {prod_reg[yuvmv_pkg::PROD_W-2:0], 1'b0}
                           + (nbits_reg[yuvmv_pkg::MUL_STEPS-1]
                              ? yuvmv_pkg::PROD_W'(mcand_reg) : '0);
                sqr_next   = {sqr_reg[yuvmv_pkg::PROD_W-2:0], 1'b0}
                           + (sbits_reg[yuvmv_pkg::MUL_STEPS-1]
                              ? yuvmv_pkg::PROD_W'(sum_reg) : '0);
                nbits_next = {nbits_reg[yuvmv_pkg::MUL_STEPS-2:0], 1'b0};
                sbits_next = {sbits_reg[yuvmv_pkg::MUL_STEPS-2:0], 1'b0};
                if (step_reg == '0)
                begin
                    // Mean dividend sum << 8, left aligned
                    dq_next    = {sum_reg, {(yuvmv_pkg::PROD_W - yuvmv_pkg::SUM_W){1'b0}}};
                    rem_next   = '0;
                    step_next  = yuvmv_pkg::STEP_W'(yuvmv_pkg::MEAN_DIV_W - 1);
                    state_next = S_DMEAN;
                end
                else
                begin
                    step_next = step_reg - yuvmv_pkg::STEP_W'(1);
                end
            end

            S_DMEAN:
            begin
                dq_next  = dq_step;
                rem_next = rem_step;
                // Odd N: N*floor(N/2) falls floor(N/2) short of floor(N^2/2)
                if (step_reg == yuvmv_pkg::STEP_W'(yuvmv_pkg::MEAN_DIV_W - 1))
                begin
                    prod_next = prod_reg + (count_reg[0]
                                ? yuvmv_pkg::PROD_W'(count_reg >> 1) : '0);
                end
                if (step_reg == '0)
                begin
                    mean_next  = dq_step[yuvmv_pkg::MEAN_W-1:0];
                    // N*sumsq + floor(N^2/2) - sum^2
                    dq_next    = prod_reg - sqr_reg;
                    rem_next   = '0;
                    step_next  = yuvmv_pkg::STEP_W'(yuvmv_pkg::PROD_W - 1);
                    state_next = S_DVAR1;
                end
                else
                begin
                    step_next = step_reg - yuvmv_pkg::STEP_W'(1);
                end
            end

            // First division by N
            S_DVAR1:
            begin
                dq_next  = dq_step;
                rem_next = rem_step;
                if (step_reg == '0)
                begin
                    dq_next    = {dq_step[yuvmv_pkg::Q1_W-1:0],
                                  {(yuvmv_pkg::PROD_W - yuvmv_pkg::Q1_W){1'b0}}};
                    rem_next   = '0;
                    step_next  = yuvmv_pkg::STEP_W'(yuvmv_pkg::Q1_W - 1);
                    state_next = S_DVAR2;
                end
                else
                begin
                    step_next = step_reg - yuvmv_pkg::STEP_W'(1);
                end
            end

            // Second division by N gives the rounded variance
            S_DVAR2:
            begin
                dq_next  = dq_step;
                rem_next = rem_step;
                if (step_reg == '0)
                begin
                    var_next   = dq_step[yuvmv_pkg::VAR_W-1:0];
                    state_next = S_FIN;
                end
                else
                begin
                    step_next = step_reg - yuvmv_pkg::STEP_W'(1);
                end
            end

            // Load the output register, clear sums, advance plane and frame
            S_FIN:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_plane_next = plane_reg;
                    out_frame_next = frame_reg;
                    out_mean_next  = mean_reg;
                    out_var_next   = var_reg;
                    count_next     = '0;
                    sum_next       = '0;
                    sumsq_next     = '0;
                    if (plane_reg == yuvmv_pkg::PLANE_V)
                    begin
                        plane_next = yuvmv_pkg::PLANE_Y;
                        frame_next = frame_reg + yuvmv_pkg::FRAME_W'(1);
                    end
                    else
                    begin
                        plane_next = plane_reg + yuvmv_pkg::PLANE_W'(1);
                    end
                    state_next = S_ACC;
                end
            end

            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            luma_reg      <= yuvmv_pkg::LUMA_W'(4096);
            count_reg     <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            plane_reg     <= yuvmv_pkg::PLANE_Y;
            frame_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            sumsq_reg     <= sumsq_next;
            plane_reg     <= plane_next;
            frame_reg     <= frame_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                luma_reg <= luma_pixels;
            end
        end
    end

    // Datapath and result payload
    always_ff @(posedge clk)
    begin
        mcand_reg     <= mcand_next;
        nbits_reg     <= nbits_next;
        sbits_reg     <= sbits_next;
        prod_reg      <= prod_next;
        sqr_reg       <= sqr_next;
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        mean_reg      <= mean_next;
        var_reg       <= var_next;
        out_plane_reg <= out_plane_next;
        out_frame_reg <= out_frame_next;
        out_mean_reg  <= out_mean_next;
        out_var_reg   <= out_var_next;
    end

`ifndef SYNTHESIS
    // Divider remainder stays below the divisor
    a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DMEAN || state_reg == S_DVAR1 || state_reg == S_DVAR2)
        |-> (rem_reg < count_reg))
        else $error("divider remainder not below sample count");

    // Sums cleared once a result is loaded
    a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (count_reg == '0 && sum_reg == '0 && sumsq_reg == '0))
        else $error("accumulators not cleared after plane result");

    // Input held off after the last pixel of a plane
    a_stall_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        plane_end |=> pixel_stall)
        else $error("pixel taken during plane computation");

    // Results stay within their ranges
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (variance <= 14'd16256 && mean_q8 <= 16'd65280))
        else $error("result out of range");

    // Plane index never goes past the V plane
    a_plane_code: assert property (@(posedge clk) disable iff (!rst_n)
        plane_reg <= yuvmv_pkg::PLANE_V)
        else $error("plane index out of range");
`endif

endmodule

/* tb/tb_yuv_plane_mean_variance.sv */
// Testbench for yuv_plane_mean_variance: drives 4:2:0 pixel streams and luma sizes,
// predicts per-plane mean and variance, and checks every result in order.
// Depends on yuvmv_pkg and the yuv_plane_mean_variance RTL.
module tb_yuv_plane_mean_variance;

    localparam int LUMA_RESET   = 4096;
    localparam int GAP_MAX      = 18;
    // A little over the per-plane computation
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 400;
    localparam int MIN_RESULTS  = 48;

    typedef struct {
        logic [yuvmv_pkg::PLANE_W-1:0] plane;
        logic [yuvmv_pkg::FRAME_W-1:0] frame_number;
        logic [yuvmv_pkg::MEAN_W-1:0]  mean_q8;
        logic [yuvmv_pkg::VAR_W-1:0]   variance;
    } plane_stats_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [yuvmv_pkg::LUMA_W-1:0]    luma_pixels;
    logic                            pixel_valid;
    logic                            pixel_stall;
    logic [yuvmv_pkg::PIX_W-1:0]     pixel;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    logic [yuvmv_pkg::PLANE_W-1:0]   plane;
    logic [yuvmv_pkg::FRAME_W-1:0]   frame_number;
    logic [yuvmv_pkg::MEAN_W-1:0]    mean_q8;
    logic [yuvmv_pkg::VAR_W-1:0]     variance;

    // Predicted block state
    logic [yuvmv_pkg::LUMA_W-1:0]    luma_setting;
    longint unsigned                 run_count;
    longint unsigned                 run_sum;
    longint unsigned                 run_squares;
    logic [yuvmv_pkg::PLANE_W-1:0]   run_plane;
    logic [yuvmv_pkg::FRAME_W-1:0]   run_frame;
    plane_stats_t                    stats_expected[$];

    int errors = 0;
    int pixels_sent = 0;
    int results_seen = 0;
    int sender_gap_max = GAP_MAX;
    int receiver_gap_max = GAP_MAX;
    int hold_cycles = 0;
    int receiver_wait = 0;

    yuv_plane_mean_variance DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .luma_pixels  (luma_pixels),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .plane        (plane),
        .frame_number (frame_number),
        .mean_q8      (mean_q8),
        .variance     (variance)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Current plane length: size rounded down to a multiple of four, clamped
    function automatic longint unsigned plane_length();
        longint unsigned n;
        n = 64'({luma_setting[yuvmv_pkg::LUMA_W-1:2], 2'b00});
        if (n < 4)
            n = 4;
        if (n > yuvmv_pkg::MAX_LUMA_PIXELS)
            n = yuvmv_pkg::MAX_LUMA_PIXELS;
        return (run_plane == yuvmv_pkg::PLANE_Y) ? n : n / 4;
    endfunction

    // Fold one accepted pixel into the plane sums; queue stats at plane end
    task automatic accumulate_pixel(input logic [yuvmv_pkg::PIX_W-1:0] px);
        plane_stats_t    s;
        longint unsigned nsq;
        longint unsigned spread;
        run_count   += 1;
        run_sum     += 64'(px);
        run_squares += 64'(px) * 64'(px);
        if (run_count < plane_length())
            return;
        nsq    = run_count * run_count;
        spread = run_count * run_squares - run_sum * run_sum;
        s.plane        = run_plane;
        s.frame_number = run_frame;
        s.mean_q8      = yuvmv_pkg::MEAN_W'((run_sum << yuvmv_pkg::MEAN_FRAC_BITS)
                                            / run_count);
        s.variance     = yuvmv_pkg::VAR_W'((spread + nsq / 2) / nsq);
        stats_expected.push_back(s);
        run_count   = 0;
        run_sum     = 0;
        run_squares = 0;
        if (run_plane == yuvmv_pkg::PLANE_V)
        begin
            run_plane = yuvmv_pkg::PLANE_Y;
            run_frame = run_frame + 1'b1;
        end
        else
        begin
            run_plane = run_plane + 1'b1;
        end
    endtask

    // One pixel request: random gap, then hold until accepted
    task automatic send_pixel(input logic [yuvmv_pkg::PIX_W-1:0] px);
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        do @(posedge clk); while (pixel_stall);
        accumulate_pixel(px);
        pixels_sent++;
    endtask

    task automatic end_burst();
        pixel_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sender pause: everything predicted has come back, block is idle
    task automatic wait_drained();
        while (stats_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_luma(input logic [yuvmv_pkg::LUMA_W-1:0] value);
        end_burst();
        wait_drained();
        cfg_valid   <= 1'b1;
        luma_pixels <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        luma_setting = value;
    endtask

    // Shrink the size mid-plane: count already past the new length
    task automatic test_reset_size_shrink();
        sender_gap_max = GAP_MAX;
        repeat (8) send_pixel(yuvmv_pkg::PIX_W'($urandom()));
        write_luma(yuvmv_pkg::LUMA_W'(0));
        repeat (3) send_pixel(yuvmv_pkg::PIX_W'($urandom()));
    endtask

    // Flat black, flat white, max spread, and a variance of exactly one half
    task automatic test_pixel_extremes();
        logic [yuvmv_pkg::PIX_W-1:0] seq [24];
        seq = '{0, 0, 0, 0, 0, 255,
                255, 255, 255, 255, 255, 0,
                0, 255, 255, 0, 128, 127,
                0, 1, 1, 2, 85, 170};
        write_luma(yuvmv_pkg::LUMA_W'(7));
        foreach (seq[i])
            send_pixel(seq[i]);
    endtask

    // Oversized and maximum sizes, then a cut down to a small plane
    task automatic test_size_clamp();
        write_luma('1);
        sender_gap_max = 0;
        for (int i = 0; i < 16; i++)
            send_pixel((i % 2) ? 8'd255 : 8'd0);
        write_luma(yuvmv_pkg::LUMA_W'(yuvmv_pkg::MAX_LUMA_PIXELS));
        repeat (4) send_pixel(8'd255);
        write_luma(yuvmv_pkg::LUMA_W'(8));
        repeat (5) send_pixel(yuvmv_pkg::PIX_W'($urandom()));
        sender_gap_max = GAP_MAX;
    endtask

    // Receiver holds off long enough that results pile up and input stalls
    task automatic test_output_backpressure();
        write_luma(yuvmv_pkg::LUMA_W'(16));
        sender_gap_max   = 0;
        receiver_gap_max = 0;
        hold_cycles      = 1500;
        repeat (48) send_pixel(yuvmv_pkg::PIX_W'($urandom()));
        sender_gap_max   = GAP_MAX;
        receiver_gap_max = GAP_MAX;
    endtask

    // Random sizes and pixel mixes; mostly small planes
    task automatic test_random_frames();
        int                          target;
        int                          burst;
        int                          mix;
        logic [yuvmv_pkg::PIX_W-1:0] base;
        logic [yuvmv_pkg::PIX_W-1:0] px;
        target = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < target || results_seen < MIN_RESULTS)
        begin
            case ($urandom_range(0, 3))
                0: begin sender_gap_max = 0;       receiver_gap_max = 0;       end
                1: begin sender_gap_max = 0;       receiver_gap_max = GAP_MAX; end
                2: begin sender_gap_max = GAP_MAX; receiver_gap_max = 0;       end
                default: begin sender_gap_max = GAP_MAX; receiver_gap_max = GAP_MAX; end
            endcase
            // Occasionally a full-range size, cut short by the next write
            if ($urandom_range(0, 4) == 0)
            begin
                write_luma(yuvmv_pkg::LUMA_W'($urandom()));
                repeat ($urandom_range(1, 12)) send_pixel(yuvmv_pkg::PIX_W'($urandom()));
            end
            if ($urandom_range(0, 7) == 0)
                write_luma(yuvmv_pkg::LUMA_W'($urandom_range(41, 300)));
            else
                write_luma(yuvmv_pkg::LUMA_W'($urandom_range(0, 40)));
            burst = $urandom_range(4, 40);
            mix   = $urandom_range(0, 3);
            base  = yuvmv_pkg::PIX_W'($urandom());
            repeat (burst)
            begin
                case (mix)
                    0: px = yuvmv_pkg::PIX_W'($urandom());
                    1: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    2: px = base;
                    default: px = base ^ yuvmv_pkg::PIX_W'($urandom_range(0, 3));
                endcase
                send_pixel(px);
            end
        end
    endtask

    // Receiver: random stall after each result, or a long hold when asked
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles  = hold_cycles - 1;
            result_stall <= 1'b1;
        end
        else if (result_valid && !result_stall)
        begin
            receiver_wait = $urandom_range(0, receiver_gap_max);
            result_stall <= (receiver_wait > 0);
        end
        else if (receiver_wait > 0)
        begin
            receiver_wait = receiver_wait - 1;
            result_stall <= (receiver_wait > 0);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        plane_stats_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (stats_expected.size() == 0)
            begin
                $error("unexpected result: plane %0d frame %0d", plane, frame_number);
                errors++;
            end
            else
            begin
                want = stats_expected.pop_front();
                if (plane !== want.plane)
                begin
                    $error("plane mismatch: expected %0d, actual %0d", want.plane, plane);
                    errors++;
                end
                if (frame_number !== want.frame_number)
                begin
                    $error("frame_number mismatch: expected %0d, actual %0d",
                           want.frame_number, frame_number);
                    errors++;
                end
                if (mean_q8 !== want.mean_q8)
                begin
                    $error("mean_q8 mismatch: expected %0d, actual %0d", want.mean_q8, mean_q8);
                    errors++;
                end
                if (variance !== want.variance)
                begin
                    $error("variance mismatch: expected %0d, actual %0d",
                           want.variance, variance);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        luma_pixels  = '0;
        pixel_valid  = 1'b0;
        pixel        = '0;
        luma_setting = yuvmv_pkg::LUMA_W'(LUMA_RESET);
        run_count    = 0;
        run_sum      = 0;
        run_squares  = 0;
        run_plane    = yuvmv_pkg::PLANE_Y;
        run_frame    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size_shrink();
        test_pixel_extremes();
        test_size_clamp();
        test_output_backpressure();
        test_random_frames();

        end_burst();
        wait_drained();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
design/yuvmv_pkg.sv
design/yuv_plane_mean_variance.sv
tb/tb_yuv_plane_mean_variance.sv
